// File: rtl/td0_pkg.sv
// ----------------------------------------------------------------------------
// td0_pkg
// Shared constants, codes and types of the TD(0) state value updater.
// ----------------------------------------------------------------------------
package td0_pkg;

  // value table
  localparam int NUM_STATES  = 1024;
  localparam int IDX_W       = $clog2(NUM_STATES);

  // item fields
  localparam int CMD_W       = 2;
  localparam int STATE_IDX_W = 10;
  localparam int VAL_W       = 32;
  localparam int ACT_W       = 8;

  // Q1.16 coefficients and datapath widths
  localparam int COEF_W      = 17;
  localparam int FRAC_W      = 16;
  localparam int ACC_W       = 36;                 // holds the TD error
  localparam int PROD_W      = ACC_W + COEF_W + 1; // signed acc times unsigned coef
  localparam int RND_W       = PROD_W - FRAC_W;

  // commands
  localparam logic [CMD_W-1:0] CMD_START = 2'd0;
  localparam logic [CMD_W-1:0] CMD_STEP  = 2'd1;
  localparam logic [CMD_W-1:0] CMD_READ  = 2'd2;

  // configuration registers
  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] CFG_LEARN_RATE = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DISCOUNT   = 1'd1;
  localparam logic [COEF_W-1:0]    LR_RESET       = 17'd6554;
  localparam logic [COEF_W-1:0]    DISC_RESET     = 17'd58982;

  // arithmetic unit operations
  localparam logic [2:0] AOP_HOLD      = 3'd0;
  localparam logic [2:0] AOP_LOAD_CUR  = 3'd1;
  localparam logic [2:0] AOP_LOAD_NEXT = 3'd2;
  localparam logic [2:0] AOP_MUL       = 3'd3;
  localparam logic [2:0] AOP_DIFF      = 3'd4;

  localparam logic COEF_SEL_GAMMA = 1'b0;
  localparam logic COEF_SEL_ALPHA = 1'b1;

  typedef struct packed {
    logic [2:0] op;
    logic       coef_sel;
  } arith_ctl_t;

endpackage

// File: rtl/td0_vmem.sv
// ----------------------------------------------------------------------------
// td0_vmem
// State value memory: one read port with registered data, one write port,
// and a zero sweep over every entry after reset.
// ----------------------------------------------------------------------------
module td0_vmem (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            rd_en,
  input  logic [td0_pkg::IDX_W-1:0]       rd_addr,
  output logic signed [td0_pkg::VAL_W-1:0] rd_data,
  input  logic                            wr_en,
  input  logic [td0_pkg::IDX_W-1:0]       wr_addr,
  input  logic signed [td0_pkg::VAL_W-1:0] wr_data,
  output logic                            clear_busy
);

  logic signed [td0_pkg::VAL_W-1:0] mem [td0_pkg::NUM_STATES];
  logic [td0_pkg::IDX_W-1:0]        clear_addr;

  logic                             we;
  logic [td0_pkg::IDX_W-1:0]        waddr;
  logic signed [td0_pkg::VAL_W-1:0] wdata;

  always_comb begin
    we    = clear_busy | wr_en;
    waddr = clear_busy ? clear_addr : wr_addr;
    wdata = clear_busy ? '0 : wr_data;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clear_busy <= 1'b1;
      clear_addr <= '0;
    end else if (clear_busy) begin
      clear_addr <= clear_addr + 1'b1;
      if (clear_addr == td0_pkg::IDX_W'(td0_pkg::NUM_STATES - 1)) begin
        clear_busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// File: rtl/td0_arith.sv
// ----------------------------------------------------------------------------
// td0_arith
// Shared multiply / round / add unit. One multiplier serves both the gamma
// and the alpha products; the saturated update comes off the product register.
// ----------------------------------------------------------------------------
module td0_arith (
  input  logic                              clk,
  input  td0_pkg::arith_ctl_t               ctl,
  input  logic signed [td0_pkg::VAL_W-1:0]  rd_data,
  input  logic signed [td0_pkg::VAL_W-1:0]  reward,
  input  logic [td0_pkg::COEF_W-1:0]        learn_rate,
  input  logic [td0_pkg::COEF_W-1:0]        discount,
  output logic signed [td0_pkg::VAL_W-1:0]  upd_value
);

  localparam int EXT_W = td0_pkg::ACC_W - td0_pkg::VAL_W;
  localparam int SUM_W = td0_pkg::RND_W + 1;

  logic signed [td0_pkg::VAL_W-1:0]  vcur;
  logic signed [td0_pkg::ACC_W-1:0]  acc;
  logic signed [td0_pkg::PROD_W-1:0] prod;

  logic [td0_pkg::COEF_W-1:0]        coef;
  logic signed [td0_pkg::COEF_W:0]   mul_b;
  logic [td0_pkg::PROD_W-1:0]        prod_rnd;
  logic [td0_pkg::RND_W-1:0]         rnd;
  logic [td0_pkg::ACC_W-1:0]         diff;
  logic [SUM_W-1:0]                  sum;
  logic [SUM_W-td0_pkg::VAL_W:0]     sum_hi;

  always_comb begin
    coef  = (ctl.coef_sel == td0_pkg::COEF_SEL_ALPHA) ? learn_rate : discount;
    mul_b = $signed({1'b0, coef});

    // round half up, then drop the fraction
    prod_rnd = prod + td0_pkg::PROD_W'(1 << (td0_pkg::FRAC_W - 1));
    rnd      = prod_rnd[td0_pkg::PROD_W-1:td0_pkg::FRAC_W];

    // gamma*V[next] + reward - V[cur]; fits in ACC_W, upper rnd bits are sign
    diff = rnd[td0_pkg::ACC_W-1:0]
         + {{EXT_W{reward[td0_pkg::VAL_W-1]}}, reward}
         - {{EXT_W{vcur[td0_pkg::VAL_W-1]}}, vcur};

    sum    = {rnd[td0_pkg::RND_W-1], rnd}
           + {{(SUM_W - td0_pkg::VAL_W){vcur[td0_pkg::VAL_W-1]}}, vcur};
    sum_hi = sum[SUM_W-1:td0_pkg::VAL_W-1];

    if (sum_hi == '0 || sum_hi == '1) begin
      upd_value = sum[td0_pkg::VAL_W-1:0];
    end else if (sum[SUM_W-1]) begin
      upd_value = {1'b1, {(td0_pkg::VAL_W-1){1'b0}}};
    end else begin
      upd_value = {1'b0, {(td0_pkg::VAL_W-1){1'b1}}};
    end
  end

  always_ff @(posedge clk) begin
    case (ctl.op)
      td0_pkg::AOP_HOLD: begin
      end
      td0_pkg::AOP_LOAD_CUR: begin
        vcur <= rd_data;
      end
      td0_pkg::AOP_LOAD_NEXT: begin
        acc <= {{EXT_W{rd_data[td0_pkg::VAL_W-1]}}, rd_data};
      end
      td0_pkg::AOP_MUL: begin
        prod <= acc * mul_b;
      end
      td0_pkg::AOP_DIFF: begin
        acc <= diff;
      end
      default: begin
      end
    endcase
  end

endmodule

// File: rtl/td0_ctrl.sv
// ----------------------------------------------------------------------------
// td0_ctrl
// Item sequencer: takes an item, steps the memory and the arithmetic unit,
// tracks the current state index and holds the result register.
// ----------------------------------------------------------------------------
module td0_ctrl (
  input  logic                                clk,
  input  logic                                rst,
  // input channel
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [td0_pkg::CMD_W-1:0]           cmd,
  input  logic [td0_pkg::STATE_IDX_W-1:0]     state_index,
  input  logic signed [td0_pkg::VAL_W-1:0]    reward,
  input  logic [td0_pkg::ACT_W-1:0]           action_count,
  // output channel
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic signed [td0_pkg::VAL_W-1:0]    value,
  output logic                                episode_end,
  // memory
  input  logic                                clear_busy,
  output logic                                rd_en,
  output logic [td0_pkg::IDX_W-1:0]           rd_addr,
  input  logic signed [td0_pkg::VAL_W-1:0]    rd_data,
  output logic                                wr_en,
  output logic [td0_pkg::IDX_W-1:0]           wr_addr,
  output logic signed [td0_pkg::VAL_W-1:0]    wr_data,
  // arithmetic unit
  output td0_pkg::arith_ctl_t                 actl,
  output logic signed [td0_pkg::VAL_W-1:0]    reward_q,
  input  logic signed [td0_pkg::VAL_W-1:0]    upd_value
);

  localparam logic [3:0] S_IDLE    = 4'd0;
  localparam logic [3:0] S_READ    = 4'd1;
  localparam logic [3:0] S_RD_NEXT = 4'd2;
  localparam logic [3:0] S_LD_NEXT = 4'd3;
  localparam logic [3:0] S_MUL_G   = 4'd4;
  localparam logic [3:0] S_DIFF    = 4'd5;
  localparam logic [3:0] S_MUL_U   = 4'd6;
  localparam logic [3:0] S_WRITE   = 4'd7;
  localparam logic [3:0] S_DONE    = 4'd8;

  logic [3:0]                       state;
  logic [3:0]                       state_next;
  logic [td0_pkg::IDX_W-1:0]        cur_index;
  logic [td0_pkg::IDX_W-1:0]        idx_q;
  logic [td0_pkg::ACT_W-1:0]        actions_q;
  logic signed [td0_pkg::VAL_W-1:0] res;
  logic                             end_q;

  logic                             accept;
  logic                             idx_ok;
  logic [td0_pkg::IDX_W-1:0]        in_idx;
  logic                             out_free;

  always_comb begin
    in_stall = (state != S_IDLE) || clear_busy;
    accept   = in_valid && !in_stall;
    idx_ok   = 32'(state_index) < 32'(td0_pkg::NUM_STATES);
    in_idx   = td0_pkg::IDX_W'(state_index);
    out_free = !out_valid || !out_stall;

    rd_en   = 1'b0;
    rd_addr = in_idx;
    if (accept) begin
      rd_en   = 1'b1;
      rd_addr = (cmd == td0_pkg::CMD_STEP) ? cur_index : in_idx;
    end else if (state == S_RD_NEXT) begin
      rd_en   = 1'b1;
      rd_addr = idx_q;
    end

    wr_en   = (state == S_WRITE);
    wr_addr = cur_index;
    wr_data = upd_value;

    actl.op       = td0_pkg::AOP_HOLD;
    actl.coef_sel = td0_pkg::COEF_SEL_GAMMA;
    state_next    = state;
    case (state)
      S_IDLE: begin
        if (accept) begin
          if (!idx_ok) begin
            state_next = S_DONE;
          end else begin
            case (cmd)
              td0_pkg::CMD_START: state_next = S_READ;
              td0_pkg::CMD_READ:  state_next = S_READ;
              td0_pkg::CMD_STEP:  state_next = S_RD_NEXT;
              default:            state_next = S_DONE;
            endcase
          end
        end
      end
      S_READ: begin
        state_next = S_DONE;
      end
      S_RD_NEXT: begin
        actl.op    = td0_pkg::AOP_LOAD_CUR;
        state_next = S_LD_NEXT;
      end
      S_LD_NEXT: begin
        actl.op    = td0_pkg::AOP_LOAD_NEXT;
        state_next = S_MUL_G;
      end
      S_MUL_G: begin
        actl.op    = td0_pkg::AOP_MUL;
        state_next = S_DIFF;
      end
      S_DIFF: begin
        actl.op    = td0_pkg::AOP_DIFF;
        state_next = S_MUL_U;
      end
      S_MUL_U: begin
        actl.op       = td0_pkg::AOP_MUL;
        actl.coef_sel = td0_pkg::COEF_SEL_ALPHA;
        state_next    = S_WRITE;
      end
      S_WRITE: begin
        state_next = S_DONE;
      end
      S_DONE: begin
        if (out_free) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      cur_index <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (accept && idx_ok && cmd == td0_pkg::CMD_START) begin
        cur_index <= in_idx;
      end
      if (state == S_WRITE) begin
        cur_index <= idx_q;
      end
      if (state == S_DONE && out_free) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (accept) begin
      idx_q     <= in_idx;
      actions_q <= action_count;
      reward_q  <= reward;
      res       <= '0;
      end_q     <= 1'b0;
    end
    if (state == S_READ) begin
      res <= rd_data;
    end
    if (state == S_WRITE) begin
      res   <= upd_value;
      end_q <= (actions_q == '0);
    end
    if (state == S_DONE && out_free) begin
      value       <= res;
      episode_end <= end_q;
    end
  end

endmodule

// File: rtl/td0_state_value_update_top.sv
// ----------------------------------------------------------------------------
// td0_state_value_update_top
// TD(0) state value learner: 1024-entry Q16.16 value table, current state,
// start / transition / read items, one result per item.
// ----------------------------------------------------------------------------
//
//   channel  | handshake                  | payload
//   ---------+----------------------------+-----------------------------------
//   input    | in_valid / in_stall        | cmd, state_index, reward,
//            |                            | action_count
//   output   | out_valid / out_stall      | value, episode_end
//   config   | cfg_we (no wait)           | cfg_index, cfg_data
//
// A transition item passes from acceptance to the next acceptance through
// two reads on the single memory read port, two passes through the one shared
// multiplier with a round/add between, the write, and the result load.
// Start and read items pass through S_READ and S_DONE; unknown items go
// straight to S_DONE. One item is in work at a time.
// After reset a sweep zeroes the table, one entry a cycle, with in_stall high
// throughout. Configuration writes are taken at any time.
// A waiting result stays in the output register; the next result is held
// back until it leaves.
module td0_state_value_update_top (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [td0_pkg::CMD_W-1:0]           cmd,
  input  logic [td0_pkg::STATE_IDX_W-1:0]     state_index,
  input  logic signed [td0_pkg::VAL_W-1:0]    reward,
  input  logic [td0_pkg::ACT_W-1:0]           action_count,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic signed [td0_pkg::VAL_W-1:0]    value,
  output logic                                episode_end,
  input  logic                                cfg_we,
  input  logic [td0_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [td0_pkg::COEF_W-1:0]          cfg_data
);

  logic [td0_pkg::COEF_W-1:0]       learn_rate;
  logic [td0_pkg::COEF_W-1:0]       discount;

  logic                             clear_busy;
  logic                             rd_en;
  logic [td0_pkg::IDX_W-1:0]        rd_addr;
  logic signed [td0_pkg::VAL_W-1:0] rd_data;
  logic                             wr_en;
  logic [td0_pkg::IDX_W-1:0]        wr_addr;
  logic signed [td0_pkg::VAL_W-1:0] wr_data;
  td0_pkg::arith_ctl_t              actl;
  logic signed [td0_pkg::VAL_W-1:0] reward_q;
  logic signed [td0_pkg::VAL_W-1:0] upd_value;

  always_ff @(posedge clk) begin
    if (rst) begin
      learn_rate <= td0_pkg::LR_RESET;
      discount   <= td0_pkg::DISC_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        td0_pkg::CFG_LEARN_RATE: learn_rate <= cfg_data;
        td0_pkg::CFG_DISCOUNT:   discount   <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  td0_vmem u_vmem (
    .clk        (clk),
    .rst        (rst),
    .rd_en      (rd_en),
    .rd_addr    (rd_addr),
    .rd_data    (rd_data),
    .wr_en      (wr_en),
    .wr_addr    (wr_addr),
    .wr_data    (wr_data),
    .clear_busy (clear_busy)
  );

  td0_arith u_arith (
    .clk        (clk),
    .ctl        (actl),
    .rd_data    (rd_data),
    .reward     (reward_q),
    .learn_rate (learn_rate),
    .discount   (discount),
    .upd_value  (upd_value)
  );

  td0_ctrl u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .cmd          (cmd),
    .state_index  (state_index),
    .reward       (reward),
    .action_count (action_count),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .value        (value),
    .episode_end  (episode_end),
    .clear_busy   (clear_busy),
    .rd_en        (rd_en),
    .rd_addr      (rd_addr),
    .rd_data      (rd_data),
    .wr_en        (wr_en),
    .wr_addr      (wr_addr),
    .wr_data      (wr_data),
    .actl         (actl),
    .reward_q     (reward_q),
    .upd_value    (upd_value)
  );

endmodule

// File: rtl/td0_checker.sv
// ----------------------------------------------------------------------------
// td0_checker
// Port-level checks of the TD(0) updater, bound to the top level.
// ----------------------------------------------------------------------------
module td0_checker (
  input logic                             clk,
  input logic                             rst,
  input logic                             in_valid,
  input logic                             in_stall,
  input logic                             out_valid,
  input logic                             out_stall,
  input logic signed [td0_pkg::VAL_W-1:0] value,
  input logic                             episode_end
);

  // held result keeps its payload
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(value) && $stable(episode_end))
    else $error("output item changed while stalled");

  // one item in work at a time
  a_one_item: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("second item taken while busy");

  // a result only shows up while the sequencer is busy with an item
  a_result_busy: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(in_stall))
    else $error("result appeared without an item in work");

  // reset starts the table sweep and empties the output
  a_reset: assert property (@(posedge clk)
    rst |=> in_stall && !out_valid)
    else $error("not blocked after reset");

endmodule

bind td0_state_value_update_top td0_checker u_td0_checker (
  .clk         (clk),
  .rst         (rst),
  .in_valid    (in_valid),
  .in_stall    (in_stall),
  .out_valid   (out_valid),
  .out_stall   (out_stall),
  .value       (value),
  .episode_end (episode_end)
);

// File: tb/sv/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for td0_state_value_update_top. A TD(0) value table
// predictor follows every accepted item and checks each returned item against
// it. Stimulus covers directed corner cases, coefficient extremes, random
// episodes under random idling, a long output hold-off and a sender pause.
// ----------------------------------------------------------------------------
module tb;

  localparam logic [td0_pkg::CMD_W-1:0] CMD_UNKNOWN = 2'd3;
  localparam int SETTLE_CYCLES = 16;   // longer than one transition
  localparam int MAX_PRINTED   = 30;
  localparam int PHASE_ITEMS   = 85;

  typedef struct packed {
    logic signed [td0_pkg::VAL_W-1:0] value;
    logic                             episode_end;
  } td_result_t;

  logic                                clk = 1'b0;
  logic                                rst = 1'b1;
  logic                                in_valid = 1'b0;
  logic                                in_stall;
  logic [td0_pkg::CMD_W-1:0]           cmd = td0_pkg::CMD_START;
  logic [td0_pkg::STATE_IDX_W-1:0]     state_index = '0;
  logic signed [td0_pkg::VAL_W-1:0]    reward = '0;
  logic [td0_pkg::ACT_W-1:0]           action_count = '0;
  logic                                out_valid;
  logic                                out_stall = 1'b0;
  logic signed [td0_pkg::VAL_W-1:0]    value;
  logic                                episode_end;
  logic                                cfg_we = 1'b0;
  logic [td0_pkg::CFG_IDX_W-1:0]       cfg_index = td0_pkg::CFG_LEARN_RATE;
  logic [td0_pkg::COEF_W-1:0]          cfg_data = '0;

  // predictor state
  logic signed [td0_pkg::VAL_W-1:0]    vtab [td0_pkg::NUM_STATES];
  logic [td0_pkg::IDX_W-1:0]           cur_state;
  logic [td0_pkg::COEF_W-1:0]          alpha_q;
  logic [td0_pkg::COEF_W-1:0]          gamma_q;
  td_result_t                          due_results [$];

  int errors = 0;
  int items_sent = 0;
  bit tx_calm = 1'b0;
  bit rx_calm = 1'b0;
  int rx_hold_left = 0;

  td0_state_value_update_top i_dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .cmd          (cmd),
    .state_index  (state_index),
    .reward       (reward),
    .action_count (action_count),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .value        (value),
    .episode_end  (episode_end),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  always #10 clk = ~clk;

  task automatic report_mismatch(input string what);
    errors++;
    if (errors <= MAX_PRINTED) $display("%0t ns: %s", $time, what);
  endtask

  // floor((x + 2^15) / 2^16): ties go up
  function automatic longint round_q16(input longint x);
    return (x + 64'sd32768) >>> 16;
  endfunction

  function automatic void td_predict(input logic [td0_pkg::CMD_W-1:0] c,
                                     input logic [td0_pkg::STATE_IDX_W-1:0] idx,
                                     input logic signed [td0_pkg::VAL_W-1:0] rew,
                                     input logic [td0_pkg::ACT_W-1:0] act);
    td_result_t r;
    longint vcur;
    longint vnext;
    longint g;
    longint d;
    longint s;
    r = '0;
    case (c)
      td0_pkg::CMD_START: begin
        cur_state = idx;
        r.value = vtab[idx];
      end
      td0_pkg::CMD_STEP: begin
        vcur  = vtab[cur_state];
        vnext = vtab[idx];
        g = round_q16(vnext * longint'(gamma_q));
        d = g + longint'(rew) - vcur;
        s = vcur + round_q16(d * longint'(alpha_q));
        if (s > 64'sd2147483647) s = 64'sd2147483647;
        else if (s < -64'sd2147483648) s = -64'sd2147483648;
        r.value = s[td0_pkg::VAL_W-1:0];
        vtab[cur_state] = r.value;
        cur_state = idx;
        r.episode_end = (act == '0);
      end
      td0_pkg::CMD_READ: begin
        r.value = vtab[idx];
      end
      default: begin
      end
    endcase
    due_results = {due_results, r};
  endfunction

  // result checker
  always @(posedge clk) begin
    td_result_t want;
    if (!rst && out_valid && !out_stall) begin
      if (due_results.size() == 0) begin
        report_mismatch($sformatf("item with nothing due: value=%h end=%b",
                                  value, episode_end));
      end else begin
        want = due_results.pop_front();
        if (value !== want.value)
          report_mismatch($sformatf("value %h, want %h", value, want.value));
        if (episode_end !== want.episode_end)
          report_mismatch($sformatf("episode_end %b, want %b", episode_end,
                                    want.episode_end));
      end
    end
  end

  // receiver: random stalls, quiet stretches and counted hold-offs
  always @(posedge clk) begin
    if (rx_hold_left > 0) begin
      out_stall <= 1'b1;
      rx_hold_left--;
    end else if (rx_calm) begin
      out_stall <= 1'b0;
    end else begin
      out_stall <= ($urandom_range(99) < 30);
    end
  end

  task automatic send_item(input logic [td0_pkg::CMD_W-1:0] c,
                           input logic [td0_pkg::STATE_IDX_W-1:0] idx,
                           input logic signed [td0_pkg::VAL_W-1:0] rew,
                           input logic [td0_pkg::ACT_W-1:0] act);
    int gap;
    gap = 0;
    if (!tx_calm && $urandom_range(99) < 30) gap = $urandom_range(1, 6);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid     <= 1'b1;
    cmd          <= c;
    state_index  <= idx;
    reward       <= rew;
    action_count <= act;
    do @(posedge clk); while (in_stall);
    td_predict(c, idx, rew, act);
    if (c != CMD_UNKNOWN) items_sent++;
  endtask

  // sender stops until every result is back, then lets the block settle
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (due_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_coefs(input logic [td0_pkg::COEF_W-1:0] a,
                             input logic [td0_pkg::COEF_W-1:0] g);
    cfg_we    <= 1'b1;
    cfg_index <= td0_pkg::CFG_LEARN_RATE;
    cfg_data  <= a;
    @(posedge clk);
    cfg_index <= td0_pkg::CFG_DISCOUNT;
    cfg_data  <= g;
    @(posedge clk);
    cfg_we <= 1'b0;
    alpha_q = a;
    gamma_q = g;
  endtask

  function automatic logic [td0_pkg::STATE_IDX_W-1:0] rand_index();
    case ($urandom_range(9))
      0: return td0_pkg::STATE_IDX_W'(td0_pkg::NUM_STATES - 1);
      1, 2: return td0_pkg::STATE_IDX_W'($urandom_range(0, td0_pkg::NUM_STATES - 1));
      default: return td0_pkg::STATE_IDX_W'($urandom_range(0, 15));
    endcase
  endfunction

  function automatic logic signed [td0_pkg::VAL_W-1:0] rand_reward();
    case ($urandom_range(9))
      0: return 32'sh7fffffff;
      1: return 32'sh80000000;
      2, 3, 4: return $urandom;
      default: return int'($urandom_range(0, 20 * 65536)) - 10 * 65536;
    endcase
  endfunction

  function automatic logic [td0_pkg::COEF_W-1:0] rand_coef();
    case ($urandom_range(7))
      0: return '0;
      1: return 17'd65536;
      2: return '1;
      3: return td0_pkg::COEF_W'($urandom_range(0, 131071));
      default: return td0_pkg::COEF_W'($urandom_range(0, 65536));
    endcase
  endfunction

  function automatic logic [td0_pkg::ACT_W-1:0] rand_actions();
    return td0_pkg::ACT_W'($urandom_range(0, 255));
  endfunction

  task automatic run_episode(input int steps);
    send_item(td0_pkg::CMD_START, rand_index(), $urandom, rand_actions());
    for (int i = 0; i < steps; i++)
      send_item(td0_pkg::CMD_STEP, rand_index(), rand_reward(),
                (i == steps - 1) ? 8'd0 : 8'($urandom_range(1, 255)));
  endtask

  task automatic send_noise();
    case ($urandom_range(4))
      0: send_item(td0_pkg::CMD_READ, rand_index(), $urandom, rand_actions());
      1: send_item(CMD_UNKNOWN,
                   td0_pkg::STATE_IDX_W'($urandom_range(0, td0_pkg::NUM_STATES - 1)),
                   $urandom, rand_actions());
      2: send_item(td0_pkg::CMD_START, rand_index(), $urandom, rand_actions());
      default: send_item(td0_pkg::CMD_STEP, rand_index(), rand_reward(), rand_actions());
    endcase
  endtask

  // first items are offered during the clearing sweep; reset coefficients in use
  task automatic test_reset_defaults();
    send_item(td0_pkg::CMD_READ, 10'd0, 32'sh0, 8'd0);
    send_item(td0_pkg::CMD_READ, 10'd1023, 32'sh0, 8'd0);
    send_item(td0_pkg::CMD_START, 10'd5, 32'sh0, 8'd0);
    send_item(td0_pkg::CMD_STEP, 10'd6, 32'sh7fffffff, 8'd3);
    // next equals current, ends the episode
    send_item(td0_pkg::CMD_STEP, 10'd6, -32'sd1, 8'd0);
    // transition after episode end
    send_item(td0_pkg::CMD_STEP, 10'd1023, 32'sh80000000, 8'd255);
    send_item(td0_pkg::CMD_READ, 10'd5, 32'sh0, 8'd0);
    send_item(td0_pkg::CMD_READ, 10'd6, 32'sh0, 8'd0);
    send_item(CMD_UNKNOWN, 10'd7, 32'sh12345678, 8'd9);
    wait_idle();
  endtask

  task automatic test_coef_extremes();
    logic [td0_pkg::COEF_W-1:0] a_set [4];
    logic [td0_pkg::COEF_W-1:0] g_set [4];
    a_set = '{17'd65536, 17'd0, 17'h1ffff, 17'h1ffff};
    g_set = '{17'd65536, 17'd0, 17'h1ffff, 17'd0};
    for (int k = 0; k < 4; k++) begin
      wait_idle();
      write_coefs(a_set[k], g_set[k]);
      send_item(td0_pkg::CMD_START, 10'd10, 32'sh0, 8'd0);
      send_item(td0_pkg::CMD_STEP, 10'd10, 32'sh7fffffff, 8'd1);   // pushes toward the top
      send_item(td0_pkg::CMD_STEP, 10'd10, 32'sh7fffffff, 8'd0);
      send_item(td0_pkg::CMD_STEP, 10'd11, 32'sh80000000, 8'd0);   // and toward the bottom
    end
    wait_idle();
  endtask

  task automatic test_random_episodes();
    int stop_at;
    for (int p = 0; p < 8; p++) begin
      wait_idle();
      write_coefs(rand_coef(), rand_coef());
      tx_calm = (p == 2);
      rx_calm = (p == 2);
      stop_at = items_sent + PHASE_ITEMS;
      while (items_sent < stop_at) begin
        if ($urandom_range(99) < 70) run_episode($urandom_range(1, 8));
        else send_noise();
      end
    end
    tx_calm = 1'b0;
    rx_calm = 1'b0;
    wait_idle();
  endtask

  // receiver holds off while the sender keeps offering: input must back up
  task automatic test_output_holdoff();
    tx_calm = 1'b1;
    rx_hold_left = 300;
    run_episode(20);
    repeat (20) send_noise();
    tx_calm = 1'b0;
    wait_idle();
  endtask

  task automatic test_sender_pause();
    run_episode(10);
    wait_idle();
    run_episode(10);
    repeat (10) send_noise();
    wait_idle();
  endtask

  initial begin
    int n;
    for (int i = 0; i < td0_pkg::NUM_STATES; i++) vtab[i] = '0;
    cur_state = '0;
    alpha_q   = td0_pkg::LR_RESET;
    gamma_q   = td0_pkg::DISC_RESET;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    test_reset_defaults();
    test_coef_extremes();
    test_random_episodes();
    test_output_holdoff();
    test_sender_pause();

    in_valid <= 1'b0;
    n = 0;
    while (due_results.size() != 0 && n < 5000) begin
      @(posedge clk);
      n++;
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (due_results.size() != 0)
      report_mismatch($sformatf("%0d results never arrived", due_results.size()));
    if (errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  // watchdog: far beyond the slowest legal run
  initial begin
    #10_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
